>>> hw/rtl/vtgl_pkg.sv
package vtgl_pkg;

   localparam int COEF_WORDS_DEF = 64;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int FIFO_DEPTH     = 2;

   // Coefficient store layout.
   localparam int W_MODEL     = 0;
   localparam int W_VIEW      = 16;
   localparam int W_PROJ      = 32;
   localparam int W_LPOS      = 48;
   localparam int LIGHT_WORDS = 11;

   // Datapath widths.
   localparam int OPND_W = 33;
   localparam int PROD_W = 66;
   localparam int ACC_W  = 67;

   localparam logic KIND_VERTEX = 1'b0;
   localparam logic KIND_WRITE  = 1'b1;

   localparam logic [1:0] CLS_VERTEX = 2'd0;
   localparam logic [1:0] CLS_WRITE  = 2'd1;
   localparam logic [1:0] CLS_DROP   = 2'd2;

   localparam logic SD_SQRT = 1'b0;
   localparam logic SD_DIV  = 1'b1;

   typedef struct packed {
      logic [1:0]         cls;
      logic [5:0]         coef_index;
      logic signed [31:0] coef_value;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] norm_x;
      logic signed [31:0] norm_y;
      logic signed [31:0] norm_z;
      logic signed [31:0] base_red;
      logic signed [31:0] base_green;
      logic signed [31:0] base_blue;
   } item_type;

   typedef struct packed {
      logic start;
      logic mode;
   } sd_ctl_type;

   function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
      logic signed [31:0] r;
      if (v[ACC_W-1:31] == '0 || v[ACC_W-1:31] == '1) begin
         r = v[31:0];
      end else if (v[ACC_W-1]) begin
         r = 32'sh8000_0000;
      end else begin
         r = 32'sh7fff_ffff;
      end
      return r;
   endfunction

endpackage

>>> hw/rtl/vtgl_ifs.sv
interface vtgl_req_if;
   logic               valid;
   logic               ready;
   logic               kind;
   logic [5:0]         coef_index;
   logic signed [31:0] coef_value;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   logic signed [31:0] norm_x;
   logic signed [31:0] norm_y;
   logic signed [31:0] norm_z;
   logic signed [31:0] base_red;
   logic signed [31:0] base_green;
   logic signed [31:0] base_blue;

   modport source (output valid, kind, coef_index, coef_value, pos_x, pos_y, pos_z,
                   norm_x, norm_y, norm_z, base_red, base_green, base_blue,
                   input ready);
   modport sink (input valid, kind, coef_index, coef_value, pos_x, pos_y, pos_z,
                 norm_x, norm_y, norm_z, base_red, base_green, base_blue,
                 output ready);
endinterface

interface vtgl_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] clip_x;
   logic signed [31:0] clip_y;
   logic signed [31:0] clip_z;
   logic signed [31:0] clip_w;
   logic signed [31:0] lit_red;
   logic signed [31:0] lit_green;
   logic signed [31:0] lit_blue;

   modport source (output valid, clip_x, clip_y, clip_z, clip_w, lit_red, lit_green,
                   lit_blue, input ready);
   modport sink (input valid, clip_x, clip_y, clip_z, clip_w, lit_red, lit_green,
                 lit_blue, output ready);
endinterface

interface vtgl_csr_if;
   logic valid;
   logic ready;
   logic light_enable;

   modport source (output valid, light_enable, input ready);
   modport sink (input valid, light_enable, output ready);
endinterface

>>> hw/rtl/vtgl_ram.sv
module vtgl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> hw/rtl/vtgl_sqdiv.sv
module vtgl_sqdiv
   import vtgl_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  sd_ctl_type  ctl,
   input  logic [63:0] radicand,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] result
);

   // One result bit per cycle. The square root consumes two radicand bits a
   // step; the divide shifts in one dividend bit a step. Since the dividend
   // magnitude never exceeds the divisor, only FRAC_BITS+1 quotient bits exist.
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic        mode_ff, mode_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] src_ff, src_in;
   logic [35:0] rem_ff, rem_in;
   logic [31:0] res_ff, res_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [35:0] rem_t;
   logic [35:0] cand;

   always_comb begin
      if (mode_ff == SD_SQRT) begin
         rem_t = {rem_ff[33:0], src_ff[63:62]};
         cand  = {2'b00, res_ff, 2'b01};
      end else begin
         rem_t = {rem_ff[34:0], src_ff[63]};
         cand  = {4'b0000, dvs_ff};
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      mode_in = mode_ff;
      cnt_in  = cnt_ff;
      src_in  = src_ff;
      rem_in  = rem_ff;
      res_in  = res_ff;
      dvs_in  = dvs_ff;
      if (busy_ff) begin
         if (rem_t >= cand) begin
            rem_in = rem_t - cand;
            res_in = {res_ff[30:0], 1'b1};
         end else begin
            rem_in = rem_t;
            res_in = {res_ff[30:0], 1'b0};
         end
         src_in = (mode_ff == SD_SQRT) ? {src_ff[61:0], 2'b00} : {src_ff[62:0], 1'b0};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (ctl.start) begin
         busy_in = 1'b1;
         mode_in = ctl.mode;
         res_in  = '0;
         dvs_in  = divisor;
         if (ctl.mode == SD_SQRT) begin
            cnt_in = 6'd32;
            src_in = radicand;
            rem_in = '0;
         end else begin
            cnt_in = 6'(FRAC_BITS + 1);
            src_in = {dividend[0], 63'b0};
            rem_in = 36'(dividend >> 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      mode_ff <= mode_in;
      cnt_ff  <= cnt_in;
      src_ff  <= src_in;
      rem_ff  <= rem_in;
      res_ff  <= res_in;
      dvs_ff  <= dvs_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

>>> hw/rtl/vtgl_fifo.sv
module vtgl_fifo
   import vtgl_pkg::*;
#(
   parameter int COEF_WORDS = COEF_WORDS_DEF
) (
   input  logic     clock,
   input  logic     reset,
   vtgl_req_if.sink req,
   output item_type head,
   output logic     head_valid,
   input  logic     head_pop
);

   localparam int PW = $clog2(FIFO_DEPTH);
   localparam int CW = $clog2(FIFO_DEPTH + 1);

   item_type         slot_ff [0:FIFO_DEPTH-1];
   item_type         slot_in [0:FIFO_DEPTH-1];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             push;
   logic             pop;
   item_type         entry;

   // Classify on the way in: writes beyond the store are marked to be dropped.
   always_comb begin
      entry.coef_index = req.coef_index;
      entry.coef_value = req.coef_value;
      entry.pos_x      = req.pos_x;
      entry.pos_y      = req.pos_y;
      entry.pos_z      = req.pos_z;
      entry.norm_x     = req.norm_x;
      entry.norm_y     = req.norm_y;
      entry.norm_z     = req.norm_z;
      entry.base_red   = req.base_red;
      entry.base_green = req.base_green;
      entry.base_blue  = req.base_blue;
      if (req.kind == KIND_VERTEX) begin
         entry.cls = CLS_VERTEX;
      end else if ({1'b0, req.coef_index} < 7'(COEF_WORDS)) begin
         entry.cls = CLS_WRITE;
      end else begin
         entry.cls = CLS_DROP;
      end
   end

   assign req.ready  = (count_ff != CW'(FIFO_DEPTH));
   assign push       = req.valid && req.ready;
   assign pop        = head_pop && head_valid;
   assign head_valid = (count_ff != '0);
   assign head       = slot_ff[rd_ptr_ff];

   always_comb begin
      slot_in   = slot_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         slot_in[wr_ptr_ff] = entry;
         wr_ptr_in = (wr_ptr_ff == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      slot_ff <= slot_in;
   end

endmodule

>>> hw/rtl/vtgl_back.sv
module vtgl_back
   import vtgl_pkg::*;
#(
   parameter int COEF_WORDS = COEF_WORDS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  item_type    head,
   input  logic        head_valid,
   output logic        head_pop,
   input  logic        light_enable,
   vtgl_rsp_if.source  rsp
);

   localparam int AW = $clog2(COEF_WORDS);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_RD   = 4'd1;
   localparam logic [3:0] ST_MUL  = 4'd2;
   localparam logic [3:0] ST_ACC  = 4'd3;
   localparam logic [3:0] ST_LRD  = 4'd4;
   localparam logic [3:0] ST_LLD  = 4'd5;
   localparam logic [3:0] ST_SQS  = 4'd6;
   localparam logic [3:0] ST_SQW  = 4'd7;
   localparam logic [3:0] ST_DVS  = 4'd8;
   localparam logic [3:0] ST_DVW  = 4'd9;
   localparam logic [3:0] ST_OUT  = 4'd10;

   localparam logic [2:0] JB_MAT = 3'd0;
   localparam logic [2:0] JB_SSN = 3'd1;
   localparam logic [2:0] JB_SSL = 3'd2;
   localparam logic [2:0] JB_DOT = 3'd3;
   localparam logic [2:0] JB_AMB = 3'd4;
   localparam logic [2:0] JB_DIF = 3'd5;
   localparam logic [2:0] JB_DCS = 3'd6;
   localparam logic [2:0] JB_SBS = 3'd7;

   logic [3:0]                state_ff, state_in;
   logic [2:0]                job_ff, job_in;
   logic [1:0]                stage_ff, stage_in;
   logic [3:0]                row_ff, row_in;
   logic [1:0]                col_ff, col_in;
   logic                      lsel_ff, lsel_in;
   logic signed [OPND_W-1:0]  vec_ff [0:3];
   logic signed [OPND_W-1:0]  vec_in [0:3];
   logic signed [31:0]        tmp_ff [0:3];
   logic signed [31:0]        tmp_in [0:3];
   logic signed [31:0]        clip_ff [0:3];
   logic signed [31:0]        clip_in [0:3];
   logic signed [31:0]        nrm_ff [0:2];
   logic signed [31:0]        nrm_in [0:2];
   logic signed [31:0]        base_ff [0:2];
   logic signed [31:0]        base_in [0:2];
   logic signed [31:0]        color_ff [0:2];
   logic signed [31:0]        color_in [0:2];
   logic signed [31:0]        un_ff [0:2];
   logic signed [31:0]        un_in [0:2];
   logic signed [31:0]        ul_ff [0:2];
   logic signed [31:0]        ul_in [0:2];
   logic signed [31:0]        lreg_ff [0:LIGHT_WORDS-1];
   logic signed [31:0]        lreg_in [0:LIGHT_WORDS-1];
   logic signed [31:0]        cos_ff, cos_in;
   logic signed [31:0]        ta_ff, ta_in;
   logic signed [31:0]        td_ff, td_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic [63:0]               ss_ff, ss_in;
   logic [31:0]               len_ff, len_in;
   logic [COEF_WORDS-1:0]     vld_ff, vld_in;
   logic                      rvld_ff, rvld_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]        oclip_ff [0:3];
   logic signed [31:0]        oclip_in [0:3];
   logic signed [31:0]        olit_ff [0:2];
   logic signed [31:0]        olit_in [0:2];

   logic                      ram_we;
   logic [AW-1:0]             ram_waddr;
   logic [AW-1:0]             ram_raddr;
   logic [31:0]               ram_rdata;
   logic [6:0]                rd_word;
   logic [6:0]                mat_base;
   logic signed [31:0]        ram_val;
   logic signed [OPND_W-1:0]  opa, opb;
   logic signed [ACC_W-1:0]   sum;
   logic signed [ACC_W-1:0]   shifted;
   logic signed [31:0]        satv;
   logic signed [31:0]        newv [0:3];
   logic [1:0]                last_row;
   logic [1:0]                last_col;
   logic [1:0]                r2;
   logic signed [OPND_W-1:0]  cur;
   logic [OPND_W-1:0]         cur_mag;
   logic signed [31:0]        qsig;
   sd_ctl_type                sd_ctl;
   logic                      sd_done;
   logic [31:0]               sd_result;

   vtgl_ram #(
      .WIDTH (32),
      .DEPTH (COEF_WORDS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (head.coef_value),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   vtgl_sqdiv #(
      .FRAC_BITS (FRAC_BITS)
   ) u_sqdiv (
      .clock    (clock),
      .reset    (reset),
      .ctl      (sd_ctl),
      .radicand (ss_ff),
      .dividend (cur_mag[31:0]),
      .divisor  (len_ff),
      .done     (sd_done),
      .result   (sd_result)
   );

   assign r2       = row_ff[1:0];
   assign cur      = vec_ff[r2];
   assign cur_mag  = cur[OPND_W-1] ? -cur : cur;
   assign qsig     = cur[OPND_W-1] ? -$signed(sd_result) : $signed(sd_result);
   // A word never written reads as zero.
   assign ram_val  = rvld_ff ? $signed(ram_rdata) : 32'sd0;
   assign ram_waddr = head.coef_index[AW-1:0];

   always_comb begin
      unique case (stage_ff)
         2'd1:    mat_base = 7'(W_VIEW);
         2'd2:    mat_base = 7'(W_PROJ);
         default: mat_base = 7'(W_MODEL);
      endcase
      if (state_ff == ST_LRD) begin
         rd_word = 7'(W_LPOS) + 7'(row_ff);
      end else begin
         rd_word = mat_base + 7'({r2, 2'b00}) + 7'(col_ff);
      end
      ram_raddr = rd_word[AW-1:0];
   end

   always_comb begin
      unique case (job_ff)
         JB_MAT: begin
            opa = cur;
            opb = OPND_W'(ram_val);
         end
         JB_SSN, JB_SSL: begin
            opa = cur;
            opb = cur;
         end
         JB_DOT: begin
            opa = OPND_W'(un_ff[r2]);
            opb = OPND_W'(ul_ff[r2]);
         end
         JB_AMB: begin
            opa = OPND_W'(lreg_ff[4'(col_ff) + 4'd3]);
            opb = OPND_W'(lreg_ff[9]);
         end
         JB_DIF: begin
            opa = OPND_W'(lreg_ff[4'(col_ff) + 4'd6]);
            opb = OPND_W'(lreg_ff[10]);
         end
         JB_DCS: begin
            opa = OPND_W'(td_ff);
            opb = OPND_W'(cos_ff);
         end
         JB_SBS: begin
            opa = OPND_W'(ta_ff);
            opb = OPND_W'(base_ff[col_ff]);
         end
         default: begin
            opa = '0;
            opb = '0;
         end
      endcase
   end

   // The floor of the exact sum over 2^FRAC_BITS is one arithmetic shift.
   assign sum     = acc_ff + ACC_W'(prod_ff);
   assign shifted = sum >>> FRAC_BITS;
   assign satv    = sat32(shifted);

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         newv[c] = (2'(c) == col_ff) ? satv : tmp_ff[c];
      end
      if (job_ff == JB_MAT) begin
         last_row = (stage_ff == 2'd3) ? 2'd2 : 2'd3;
      end else if (job_ff == JB_SSN || job_ff == JB_SSL || job_ff == JB_DOT) begin
         last_row = 2'd2;
      end else begin
         last_row = 2'd0;
      end
      last_col = (stage_ff == 2'd3) ? 2'd2 : 2'd3;
   end

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      stage_in     = stage_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      lsel_in      = lsel_ff;
      vec_in       = vec_ff;
      tmp_in       = tmp_ff;
      clip_in      = clip_ff;
      nrm_in       = nrm_ff;
      base_in      = base_ff;
      color_in     = color_ff;
      un_in        = un_ff;
      ul_in        = ul_ff;
      lreg_in      = lreg_ff;
      cos_in       = cos_ff;
      ta_in        = ta_ff;
      td_in        = td_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      ss_in        = ss_ff;
      len_in       = len_ff;
      vld_in       = vld_ff;
      rvld_in      = vld_ff[ram_raddr];
      oclip_in     = oclip_ff;
      olit_in      = olit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      head_pop     = 1'b0;
      ram_we       = 1'b0;
      sd_ctl.start = 1'b0;
      sd_ctl.mode  = SD_SQRT;

      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               head_pop = 1'b1;
               if (head.cls == CLS_WRITE) begin
                  ram_we = 1'b1;
                  vld_in[ram_waddr] = 1'b1;
               end else if (head.cls == CLS_VERTEX) begin
                  vec_in[0]  = OPND_W'(head.pos_x);
                  vec_in[1]  = OPND_W'(head.pos_y);
                  vec_in[2]  = OPND_W'(head.pos_z);
                  vec_in[3]  = OPND_W'(1) << FRAC_BITS;
                  nrm_in[0]  = head.norm_x;
                  nrm_in[1]  = head.norm_y;
                  nrm_in[2]  = head.norm_z;
                  base_in[0] = head.base_red;
                  base_in[1] = head.base_green;
                  base_in[2] = head.base_blue;
                  stage_in   = 2'd0;
                  job_in     = JB_MAT;
                  row_in     = '0;
                  col_in     = '0;
                  acc_in     = '0;
                  state_in   = ST_RD;
               end
            end
         end
         ST_RD: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = PROD_W'(opa) * PROD_W'(opb);
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (r2 != last_row) begin
               acc_in   = sum;
               row_in   = row_ff + 4'd1;
               state_in = ST_RD;
            end else begin
               acc_in   = '0;
               row_in   = '0;
               state_in = ST_RD;
               unique case (job_ff)
                  JB_MAT: begin
                     tmp_in[col_ff] = satv;
                     if (col_ff != last_col) begin
                        col_in = col_ff + 2'd1;
                     end else begin
                        col_in = '0;
                        unique case (stage_ff)
                           2'd0, 2'd1: begin
                              for (int c = 0; c < 4; c++) begin
                                 vec_in[c] = OPND_W'(newv[c]);
                              end
                              stage_in = stage_ff + 2'd1;
                           end
                           2'd2: begin
                              clip_in = newv;
                              if (light_enable) begin
                                 state_in = ST_LRD;
                              end else begin
                                 color_in = base_ff;
                                 state_in = ST_OUT;
                              end
                           end
                           default: begin
                              for (int c = 0; c < 3; c++) begin
                                 vec_in[c] = OPND_W'(newv[c]);
                              end
                              job_in  = JB_SSN;
                              lsel_in = 1'b0;
                           end
                        endcase
                     end
                  end
                  JB_SSN, JB_SSL: begin
                     ss_in    = sum[63:0];
                     state_in = ST_SQS;
                  end
                  JB_DOT: begin
                     cos_in = satv[31] ? 32'sd0 : satv;
                     job_in = JB_AMB;
                     col_in = '0;
                  end
                  JB_AMB: begin
                     ta_in  = satv;
                     job_in = JB_DIF;
                  end
                  JB_DIF: begin
                     td_in  = satv;
                     job_in = JB_DCS;
                  end
                  JB_DCS: begin
                     ta_in  = sat32(ACC_W'(ta_ff) + ACC_W'(satv));
                     job_in = JB_SBS;
                  end
                  default: begin
                     color_in[col_ff] = satv;
                     if (col_ff == 2'd2) begin
                        state_in = ST_OUT;
                     end else begin
                        col_in = col_ff + 2'd1;
                        job_in = JB_AMB;
                     end
                  end
               endcase
            end
         end
         ST_LRD: begin
            state_in = ST_LLD;
         end
         ST_LLD: begin
            lreg_in[row_ff] = ram_val;
            if (row_ff == 4'(LIGHT_WORDS - 1)) begin
               row_in = '0;
               col_in = '0;
               for (int c = 0; c < 3; c++) begin
                  vec_in[c] = OPND_W'(nrm_ff[c]);
               end
               stage_in = 2'd3;
               job_in   = JB_MAT;
               state_in = ST_RD;
            end else begin
               row_in   = row_ff + 4'd1;
               state_in = ST_LRD;
            end
         end
         ST_SQS: begin
            sd_ctl.start = 1'b1;
            sd_ctl.mode  = SD_SQRT;
            state_in     = ST_SQW;
         end
         ST_SQW: begin
            if (sd_done) begin
               len_in = sd_result;
               row_in = '0;
               if (sd_result == '0) begin
                  // A zero-length vector leaves the diffuse term at zero.
                  cos_in   = 32'sd0;
                  job_in   = JB_AMB;
                  col_in   = '0;
                  state_in = ST_RD;
               end else begin
                  state_in = ST_DVS;
               end
            end
         end
         ST_DVS: begin
            sd_ctl.start = 1'b1;
            sd_ctl.mode  = SD_DIV;
            state_in     = ST_DVW;
         end
         ST_DVW: begin
            if (sd_done) begin
               if (lsel_ff) begin
                  ul_in[r2] = qsig;
               end else begin
                  un_in[r2] = qsig;
               end
               if (r2 == 2'd2) begin
                  row_in   = '0;
                  state_in = ST_RD;
                  if (!lsel_ff) begin
                     lsel_in = 1'b1;
                     for (int c = 0; c < 3; c++) begin
                        vec_in[c] = -OPND_W'(lreg_ff[c]);
                     end
                     job_in = JB_SSL;
                  end else begin
                     job_in = JB_DOT;
                  end
               end else begin
                  row_in   = row_ff + 4'd1;
                  state_in = ST_DVS;
               end
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               oclip_in     = clip_ff;
               olit_in      = color_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         vld_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         vld_ff       <= vld_in;
      end
      job_ff   <= job_in;
      stage_ff <= stage_in;
      row_ff   <= row_in;
      col_ff   <= col_in;
      lsel_ff  <= lsel_in;
      vec_ff   <= vec_in;
      tmp_ff   <= tmp_in;
      clip_ff  <= clip_in;
      nrm_ff   <= nrm_in;
      base_ff  <= base_in;
      color_ff <= color_in;
      un_ff    <= un_in;
      ul_ff    <= ul_in;
      lreg_ff  <= lreg_in;
      cos_ff   <= cos_in;
      ta_ff    <= ta_in;
      td_ff    <= td_in;
      acc_ff   <= acc_in;
      prod_ff  <= prod_in;
      ss_ff    <= ss_in;
      len_ff   <= len_in;
      rvld_ff  <= rvld_in;
      oclip_ff <= oclip_in;
      olit_ff  <= olit_in;
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.clip_x    = oclip_ff[0];
   assign rsp.clip_y    = oclip_ff[1];
   assign rsp.clip_z    = oclip_ff[2];
   assign rsp.clip_w    = oclip_ff[3];
   assign rsp.lit_red   = olit_ff[0];
   assign rsp.lit_green = olit_ff[1];
   assign rsp.lit_blue  = olit_ff[2];

endmodule

>>> hw/rtl/vertex_transform_gouraud_light.sv
// Channel    Dir  Transfer when        Carries
// req_chan   in   valid && ready       vertex or coefficient write
// rsp_chan   out  valid && ready       clip position and lit color
// csr_chan   in   valid && ready       light_enable (ready is always high)
//
// The back end stores a coefficient write from its idle state; a vertex's time
// is set by the one shared 33x33 multiplier (read, multiply and accumulate per
// term) and the bit-per-cycle root/divide unit, which only lit vertices use.
// A two-entry queue accepts until full while the back end works or the result
// register waits. Reset is synchronous; stored coefficients read as zero
// until written, through per-word valid bits, so no clearing pass is needed.
module vertex_transform_gouraud_light
   import vtgl_pkg::*;
#(
   parameter int COEF_WORDS = COEF_WORDS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   vtgl_req_if.sink   req_chan,
   vtgl_rsp_if.source rsp_chan,
   vtgl_csr_if.sink   csr_chan
);

   item_type head;
   logic     head_valid;
   logic     head_pop;
   logic     light_en_ff, light_en_in;

   assign csr_chan.ready = 1'b1;
   assign light_en_in    = csr_chan.valid ? csr_chan.light_enable : light_en_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         light_en_ff <= 1'b0;
      end else begin
         light_en_ff <= light_en_in;
      end
   end

   vtgl_fifo #(
      .COEF_WORDS (COEF_WORDS)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .head       (head),
      .head_valid (head_valid),
      .head_pop   (head_pop)
   );

   vtgl_back #(
      .COEF_WORDS (COEF_WORDS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .head_valid   (head_valid),
      .head_pop     (head_pop),
      .light_enable (light_en_ff),
      .rsp          (rsp_chan)
   );

endmodule

>>> hw/rtl/vtgl_checker.sv
module vtgl_checker
   import vtgl_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_kind,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_clip_x,
   input logic [31:0] rsp_lit_red
);

   logic [3:0] pend_ff, pend_in;
   logic       vin;
   logic       vout;

   assign vin  = req_valid && req_ready && (req_kind == KIND_VERTEX);
   assign vout = rsp_valid && rsp_ready;

   always_comb begin
      pend_in = pend_ff;
      if (vin && !vout) begin
         pend_in = pend_ff + 4'd1;
      end else if (vout && !vin) begin
         pend_in = pend_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_clip_x) && $stable(rsp_lit_red))
      else $error("result changed while stalled");

   // Every result must belong to a vertex that was taken and not yet answered.
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 4'd0)
      else $error("result without an outstanding vertex");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind vertex_transform_gouraud_light vtgl_checker u_vtgl_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .req_kind    (req_chan.kind),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_clip_x  (rsp_chan.clip_x),
   .rsp_lit_red (rsp_chan.lit_red)
);

>>> sim/testbench.sv
module testbench;
   import vtgl_pkg::*;

   localparam int FRAC = 16;
   localparam int LIMIT = 20000;
   localparam int SETTLE = 600;

   typedef struct {
      logic signed [31:0] cx, cy, cz, cw, r, g, b;
   } vertex_out_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   vtgl_req_if req_chan();
   vtgl_rsp_if rsp_chan();
   vtgl_csr_if csr_chan();

   vertex_transform_gouraud_light u_dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source),
      .csr_chan(csr_chan.sink)
   );

   longint coef_model[64];
   bit lighting_on;
   vertex_out_type pending_vertices[$];
   int errors = 0;
   int checked = 0;
   int lit_checked = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_off = 0;
   int idle_cycles = 0;

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint floor_q(longint x);
      return x >>> FRAC;
   endfunction

   // Exact floor of a sum of products: split each product to keep within 64 bits.
   function automatic longint fixed_dot(longint a[4], longint b[4], int n);
      longint hi, lo, p, q;
      hi = 0;
      lo = 0;
      for (int i = 0; i < n; i++) begin
         p = a[i] * b[i];
         q = floor_q(p);
         hi += q;
         lo += p - (q <<< FRAC);
      end
      return hi + (lo >>> FRAC);
   endfunction

   function automatic longint fixed_mul(longint a, longint b);
      return clamp32(floor_q(a * b));
   endfunction

   function automatic void row_times_matrix(longint v[4], int base, int n,
                                            output longint res[4]);
      longint col[4];
      for (int c = 0; c < 4; c++) begin
         col = '{0, 0, 0, 0};
         for (int r = 0; r < n; r++) col[r] = coef_model[base + 4 * r + c];
         res[c] = (c < n) ? clamp32(fixed_dot(v, col, n)) : 0;
      end
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r, bt;
      r = 0;
      bt = 64'd1 << 62;
      while (bt > x) bt >>= 2;
      while (bt != 0) begin
         if (x >= r + bt) begin
            x -= r + bt;
            r = (r >> 1) + bt;
         end else begin
            r >>= 1;
         end
         bt >>= 2;
      end
      return r;
   endfunction

   function automatic bit to_unit(longint v[4], output longint u[4]);
      longint unsigned ss, m, len;
      ss = 0;
      u = '{0, 0, 0, 0};
      for (int i = 0; i < 3; i++) begin
         m = (v[i] < 0) ? -v[i] : v[i];
         ss += m * m;
      end
      len = int_sqrt(ss);
      if (len == 0) return 1'b0;
      for (int i = 0; i < 3; i++) u[i] = (v[i] * 65536) / longint'(len);
      return 1'b1;
   endfunction

   function automatic vertex_out_type shade_vertex(item_type it);
      longint p[4], m1[4], m2[4], m3[4], nv[4], nm[4], ln[4], un[4], ul[4];
      longint colr[3], cosv, acc, a, d, s;
      vertex_out_type o;
      p = '{it.pos_x, it.pos_y, it.pos_z, 64'sd1 <<< FRAC};
      row_times_matrix(p, W_MODEL, 4, m1);
      row_times_matrix(m1, W_VIEW, 4, m2);
      row_times_matrix(m2, W_PROJ, 4, m3);
      colr = '{it.base_red, it.base_green, it.base_blue};
      if (lighting_on) begin
         nv = '{it.norm_x, it.norm_y, it.norm_z, 0};
         ln = '{-coef_model[W_LPOS], -coef_model[W_LPOS + 1], -coef_model[W_LPOS + 2], 0};
         row_times_matrix(nv, W_MODEL, 3, nm);
         cosv = 0;
         if (to_unit(nm, un) && to_unit(ln, ul)) begin
            acc = un[0] * ul[0] + un[1] * ul[1] + un[2] * ul[2];
            cosv = floor_q(acc);
            if (cosv < 0) cosv = 0;
         end
         for (int i = 0; i < 3; i++) begin
            a = fixed_mul(coef_model[51 + i], coef_model[57]);
            d = fixed_mul(coef_model[54 + i], coef_model[58]);
            s = clamp32(a + fixed_mul(d, cosv));
            colr[i] = fixed_mul(s, colr[i]);
         end
      end
      o.cx = m3[0];
      o.cy = m3[1];
      o.cz = m3[2];
      o.cw = m3[3];
      o.r = colr[0];
      o.g = colr[1];
      o.b = colr[2];
      return o;
   endfunction

   initial begin
      req_chan.valid = 1'b0;
      req_chan.kind = KIND_VERTEX;
      req_chan.coef_index = '0;
      req_chan.coef_value = '0;
      req_chan.pos_x = '0;
      req_chan.pos_y = '0;
      req_chan.pos_z = '0;
      req_chan.norm_x = '0;
      req_chan.norm_y = '0;
      req_chan.norm_z = '0;
      req_chan.base_red = '0;
      req_chan.base_green = '0;
      req_chan.base_blue = '0;
      rsp_chan.ready = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.light_enable = 1'b0;
   end

   // Receiver: random stalls plus an optional long hold-off.
   always @(posedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_vertices.size() == 0) begin
            $display("%0t: unexpected result x=%h", $time, rsp_chan.clip_x);
            errors++;
         end else begin
            vertex_out_type e;
            e = pending_vertices.pop_front();
            if (e.cx !== rsp_chan.clip_x) begin
               $display("%0t: clip_x exp %h got %h", $time, e.cx, rsp_chan.clip_x);
               errors++;
            end
            if (e.cy !== rsp_chan.clip_y) begin
               $display("%0t: clip_y exp %h got %h", $time, e.cy, rsp_chan.clip_y);
               errors++;
            end
            if (e.cz !== rsp_chan.clip_z) begin
               $display("%0t: clip_z exp %h got %h", $time, e.cz, rsp_chan.clip_z);
               errors++;
            end
            if (e.cw !== rsp_chan.clip_w) begin
               $display("%0t: clip_w exp %h got %h", $time, e.cw, rsp_chan.clip_w);
               errors++;
            end
            if (e.r !== rsp_chan.lit_red) begin
               $display("%0t: lit_red exp %h got %h", $time, e.r, rsp_chan.lit_red);
               errors++;
            end
            if (e.g !== rsp_chan.lit_green) begin
               $display("%0t: lit_green exp %h got %h", $time, e.g, rsp_chan.lit_green);
               errors++;
            end
            if (e.b !== rsp_chan.lit_blue) begin
               $display("%0t: lit_blue exp %h got %h", $time, e.b, rsp_chan.lit_blue);
               errors++;
            end
            checked++;
         end
      end
   end

   // Watchdog on cycles with no transfer on either channel.
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
          reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Valid stays high after a transfer so that back-to-back items need no gap;
   // it drops only while the sender idles or before a drain.
   task automatic send_item(item_type it);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.kind <= (it.cls == CLS_WRITE) ? KIND_WRITE : KIND_VERTEX;
      req_chan.coef_index <= it.coef_index;
      req_chan.coef_value <= it.coef_value;
      req_chan.pos_x <= it.pos_x;
      req_chan.pos_y <= it.pos_y;
      req_chan.pos_z <= it.pos_z;
      req_chan.norm_x <= it.norm_x;
      req_chan.norm_y <= it.norm_y;
      req_chan.norm_z <= it.norm_z;
      req_chan.base_red <= it.base_red;
      req_chan.base_green <= it.base_green;
      req_chan.base_blue <= it.base_blue;
      do @(posedge clock); while (!req_chan.ready);
      if (it.cls == CLS_WRITE) begin
         coef_model[it.coef_index] = it.coef_value;
      end else begin
         pending_vertices.push_back(shade_vertex(it));
         if (lighting_on) lit_checked++;
      end
   endtask

   task automatic write_coef(int idx, logic signed [31:0] val);
      item_type it;
      it = '0;
      it.cls = CLS_WRITE;
      it.coef_index = 6'(idx);
      it.coef_value = val;
      it.pos_x = $urandom;
      send_item(it);
   endtask

   function automatic logic signed [31:0] rand_word(int mode);
      case (mode)
         0: return $urandom;
         1: return $signed($urandom_range(131072)) - 65536;
         2: return ($urandom_range(1)) ? 32'sh7fff_ffff : 32'sh8000_0000;
         default: return $signed($urandom_range(8 << 16)) - (4 << 16);
      endcase
   endfunction

   task automatic send_vertex(int mode);
      item_type it;
      it.cls = CLS_VERTEX;
      it.coef_index = 6'($urandom);
      it.coef_value = $urandom;
      it.pos_x = rand_word(mode);
      it.pos_y = rand_word(mode);
      it.pos_z = rand_word(mode);
      it.norm_x = rand_word(mode);
      it.norm_y = rand_word(mode);
      it.norm_z = rand_word(mode);
      it.base_red = rand_word(mode);
      it.base_green = rand_word(mode);
      it.base_blue = rand_word(mode);
      send_item(it);
   endtask

   task automatic drain;
      req_chan.valid <= 1'b0;
      while (pending_vertices.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_lighting(bit en);
      drain();
      csr_chan.valid <= 1'b1;
      csr_chan.light_enable <= en;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      lighting_on = en;
   endtask

   task automatic load_scene(int mode);
      for (int i = 0; i < 59; i++) begin
         if (i % 5 == 0 && i < 48)
            write_coef(i, 32'sd1 <<< FRAC);
         else
            write_coef(i, rand_word(mode));
      end
   endtask

   task automatic test_directed;
      item_type it;
      // Zero store: every vertex maps to the origin.
      send_vertex(2);
      write_coef(63, 32'sh1234_5678);
      write_coef(0, 32'sh7fff_ffff);
      write_coef(5, 32'sh8000_0000);
      send_vertex(2);
      load_scene(1);
      set_lighting(1'b1);
      send_vertex(1);
      it = '0;
      it.cls = CLS_VERTEX;
      it.base_red = 32'sh7fff_ffff;
      it.base_green = 32'sh8000_0000;
      it.base_blue = 32'sh0001_0000;
      send_item(it);
      // Zero-length light vector.
      write_coef(W_LPOS, 0);
      write_coef(W_LPOS + 1, 0);
      write_coef(W_LPOS + 2, 0);
      send_vertex(1);
      send_vertex(2);
      send_vertex(0);
   endtask

   task automatic test_random(int count, bit en);
      int mode;
      set_lighting(en);
      load_scene($urandom_range(3));
      for (int n = 0; n < count; n++) begin
         mode = $urandom_range(3);
         if ($urandom_range(19) == 0)
            write_coef($urandom_range(63), rand_word(mode));
         else
            send_vertex(mode);
      end
   endtask

   task automatic test_backpressure;
      hold_off = 3000;
      for (int n = 0; n < 12; n++) send_vertex(3);
      drain();
      for (int n = 0; n < 6; n++) send_vertex(1);
   endtask

   initial begin
      for (int i = 0; i < 64; i++) coef_model[i] = 0;
      lighting_on = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      send_idle_pct = 16;
      recv_idle_pct = 82;
      test_random(140, 1'b0);
      test_random(140, 1'b1);
      send_idle_pct = 82;
      recv_idle_pct = 16;
      test_random(140, 1'b1);
      test_random(140, 1'b0);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_backpressure();
      test_random(120, 1'b1);
      test_random(120, 1'b0);
      drain();
      $display("Checked %0d vertices, %0d of them lit, across coefficient reloads",
               checked, lit_checked);
      $display("and both lighting settings under sender and receiver stalls.");
      if (errors == 0 && pending_vertices.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

>>> files.f
hw/rtl/vtgl_pkg.sv
hw/rtl/vtgl_ifs.sv
hw/rtl/vtgl_ram.sv
hw/rtl/vtgl_sqdiv.sv
hw/rtl/vtgl_fifo.sv
hw/rtl/vtgl_back.sv
hw/rtl/vertex_transform_gouraud_light.sv
hw/rtl/vtgl_checker.sv
sim/testbench.sv
